>>> rtl/core/olca_pkg.sv
`default_nettype none
package olca_pkg;

  localparam int Dims        = 4;
  localparam int MaxClusters = 16;
  localparam int DimW        = $clog2(Dims);
  localparam int DimCntW     = $clog2(Dims + 1);
  localparam int ClW         = $clog2(MaxClusters);
  localparam int ClCntW      = $clog2(MaxClusters + 1);
  localparam int AddrW       = ClW + DimW;
  localparam int Depth       = MaxClusters * Dims;

  localparam logic [23:0] RelSat = 24'hFFFFFF;
  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic [1:0] StTraining = 2'd0;
  localparam logic [1:0] StFinished = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StDetect   = 2'd3;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegLimit  = 2'd1;
  localparam logic [1:0] RegSmooth = 2'd2;
  localparam logic [1:0] RegTrain  = 2'd3;

endpackage
`default_nettype wire

>>> rtl/core/olca_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle: quo = min(mag*65536/den, 2^24-1)
module olca_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] mag_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [23:0]      rel_o
);
  import olca_pkg::*;

  // quotient needs at most 49 bits; only 25 matter for saturation
  logic [48:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [48:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      num_d  = {mag_i, 16'h0000};
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[48]} - {2'b00, den_q};
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[47:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[48]};
        quo_d = {quo_q[47:0], 1'b0};
      end
      num_d = {num_q[47:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rel_o  = (den_q == 32'd0 || quo_q[48:24] != 25'd0) ? RelSat : quo_q[23:0];

endmodule
`default_nettype wire

>>> rtl/core/online_leader_clustering_anomaly.sv
`default_nettype none
// an item without last_element is only buffered; a closing item scans the clusters one
// element at a time, then updates the matched centroid or (training) stores a new cluster;
// each element scanned pays a 49-step bit-serial divide
// throughput: one vector at a time, ready is low from the closing item until its result is taken
// reset: asynchronous active low; clears state, counters and config; datapath registers and
// the centroid table are not cleared (only entries below cluster_count are read)
module online_leader_clustering_anomaly (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] element_value_i,
  input  wire logic        last_element_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic             is_anomaly_o,
  output logic [15:0]      anomaly_count_o,
  output logic [4:0]       cluster_count_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import olca_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDecide = 4'd1;
  localparam logic [3:0] SRead   = 4'd2;
  localparam logic [3:0] SRdWait = 4'd3;
  localparam logic [3:0] SDiv    = 4'd4;
  localparam logic [3:0] SSq     = 4'd5;
  localparam logic [3:0] SAcc    = 4'd6;
  localparam logic [3:0] SCmp    = 4'd7;
  localparam logic [3:0] SUpRd   = 4'd8;
  localparam logic [3:0] SUpWait = 4'd9;
  localparam logic [3:0] SUpMul  = 4'd10;
  localparam logic [3:0] SUpWr   = 4'd11;
  localparam logic [3:0] SStore  = 4'd12;
  localparam logic [3:0] SFinish = 4'd13;
  localparam logic [3:0] SOut    = 4'd14;

  logic        mode_q;
  logic [15:0] limit_q;
  logic [16:0] smooth_q;
  logic [15:0] tlen_q;

  logic [3:0]  st_q, st_d;
  logic [15:0] vbuf_q [Dims];
  logic [DimCntW-1:0] eidx_q;
  logic [ClCntW-1:0]  ccount_q;
  logic        seeded_q;
  logic [15:0] trained_q;
  logic [15:0] atotal_q;
  logic [ClW-1:0]  k_q;
  logic [DimW-1:0] j_q;
  logic [31:0] c_q;
  logic [23:0] rel_q;
  logic [47:0] sq_q;
  logic [49:0] sum_q;
  logic [1:0]  status_q;
  logic        anom_q;
  logic [31:0] mem [Depth];
  logic [31:0] rd_q;
  logic        div_start, div_done;
  logic [23:0] div_rel;
  logic [32:0] mag;
  logic [31:0] den;
  logic signed [33:0] diff;
  logic [16:0] alpha;
  logic signed [51:0] tsum_q;
  logic [1:0]  up_ph_q;

  wire apb_wr = psel && penable && pwrite;
  wire [1:0] reg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegMode:   prdata = {31'd0, mode_q};
      RegLimit:  prdata = {16'd0, limit_q};
      RegSmooth: prdata = {15'd0, smooth_q};
      RegTrain:  prdata = {16'd0, tlen_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      limit_q  <= 16'd256;
      smooth_q <= 17'd32768;
      tlen_q   <= 16'd1000;
    end else if (apb_wr) begin
      case (reg_idx)
        RegMode:   mode_q   <= pwdata[0];
        RegLimit:  limit_q  <= pwdata[15:0];
        RegSmooth: smooth_q <= pwdata[16:0];
        RegTrain:  tlen_q   <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  assign in_ready_o  = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);
  assign status_o        = status_q;
  assign is_anomaly_o    = anom_q;
  assign anomaly_count_o = atotal_q;
  assign cluster_count_o = ClCntW'(ccount_q);

  wire [AddrW-1:0] addr = {k_q, j_q};
  wire signed [15:0] sv = vbuf_q[j_q];
  wire last_j = (j_q == DimW'(Dims - 1));
  wire [49:0] lim2 = 50'({limit_q, 8'h00}) * 50'({limit_q, 8'h00});
  wire [15:0] trained_inc = (trained_q == 16'hFFFF) ? trained_q : trained_q + 16'd1;

  assign diff  = 34'(signed'(c_q)) - 34'({{2{sv[15]}}, sv, 16'h0000});
  assign mag   = diff[33] ? 33'(-diff) : 33'(diff);
  assign den   = c_q[31] ? -c_q : c_q;
  assign alpha = (smooth_q > OneQ16) ? OneQ16 : smooth_q;
  assign div_start = (st_q == SDiv) && (up_ph_q == 2'd0);

  olca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag),
    .den_i   (den),
    .done_o  (div_done),
    .rel_o   (div_rel)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == SStore) mem[addr] <= {vbuf_q[j_q], 16'h0000};
    else if (st_q == SUpWr) mem[addr] <= tsum_q[47:16];
    rd_q <= mem[addr];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle:   if (in_valid_i && last_element_i) st_d = SDecide;
      SDecide: begin
        if (mode_q == 1'b0 && !seeded_q) st_d = SStore;
        else if (ccount_q == '0) st_d = SFinish;
        else st_d = SRead;
      end
      SRead:   st_d = SRdWait;
      SRdWait: st_d = SDiv;
      SDiv:    if (div_done) st_d = SSq;
      SSq:     st_d = SAcc;
      SAcc:    st_d = last_j ? SCmp : SRead;
      SCmp: begin
        if (sum_q < lim2) st_d = SUpRd;
        else if (ClCntW'(k_q) + 1'b1 >= ccount_q) begin
          if (mode_q == 1'b0 && ccount_q < ClCntW'(MaxClusters)) st_d = SStore;
          else st_d = SFinish;
        end else st_d = SRead;
      end
      SUpRd:   st_d = SUpWait;
      SUpWait: st_d = SUpMul;
      SUpMul:  if (up_ph_q == 2'd1) st_d = SUpWr;
      SUpWr:   st_d = last_j ? SFinish : SUpRd;
      SStore:  st_d = last_j ? SFinish : SStore;
      SFinish: st_d = SOut;
      SOut:    if (out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SIdle;
      eidx_q    <= '0;
      ccount_q  <= '0;
      seeded_q  <= 1'b0;
      trained_q <= '0;
      atotal_q  <= '0;
      status_q  <= StTraining;
      anom_q    <= 1'b0;
      k_q       <= '0;
      j_q       <= '0;
      up_ph_q   <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        SIdle: if (in_valid_i) begin
          if (last_element_i) eidx_q <= '0;
          else if (eidx_q < DimCntW'(Dims)) eidx_q <= eidx_q + 1'b1;
          k_q <= '0;
          j_q <= '0;
          anom_q <= 1'b0;
        end
        SDecide: begin
          j_q <= '0;
          k_q <= (mode_q == 1'b0 && !seeded_q) ? '0 : '0;
          // nothing to match against, so the vector is an anomaly
          if (!(mode_q == 1'b0 && !seeded_q) && ccount_q == '0) anom_q <= 1'b1;
        end
        SRdWait: up_ph_q <= '0;
        SDiv: if (up_ph_q == 2'd0) up_ph_q <= 2'd1;
        SAcc: j_q <= j_q + 1'b1;
        SCmp: begin
          j_q <= '0;
          if (!(sum_q < lim2)) begin
            if (ClCntW'(k_q) + 1'b1 >= ccount_q) begin
              anom_q <= 1'b1;
              if (mode_q == 1'b0 && ccount_q < ClCntW'(MaxClusters))
                k_q <= ClW'(ccount_q);
            end else k_q <= k_q + 1'b1;
          end
        end
        SUpWait: up_ph_q <= '0;
        SUpMul: up_ph_q <= up_ph_q + 2'd1;
        SUpWr:  j_q <= j_q + 1'b1;
        SStore: j_q <= j_q + 1'b1;
        SFinish: begin
          if (mode_q) begin
            status_q <= StDetect;
            if (anom_q && atotal_q != 16'hFFFF) atotal_q <= atotal_q + 16'd1;
          end else if (!seeded_q) begin
            seeded_q  <= 1'b1;
            ccount_q  <= ClCntW'(1);
            trained_q <= trained_inc;
            status_q  <= (trained_inc < tlen_q) ? StTraining : StFinished;
          end else if (!anom_q) begin
            trained_q <= trained_inc;
            status_q  <= (trained_inc < tlen_q) ? StTraining : StFinished;
          end else if (ccount_q >= ClCntW'(MaxClusters)) begin
            status_q <= StFull;
          end else begin
            ccount_q <= ccount_q + 1'b1;
            if (ccount_q + 1'b1 >= ClCntW'(MaxClusters)) status_q <= StFull;
            else begin
              trained_q <= trained_inc;
              status_q  <= (trained_inc < tlen_q) ? StTraining : StFinished;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // vector buffer; missing elements are zeroed on the closing item
  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_valid_i) begin
      for (int i = 0; i < Dims; i++) begin
        if (eidx_q == DimCntW'(i)) vbuf_q[i] <= element_value_i;
        else if (last_element_i && eidx_q < DimCntW'(i)) vbuf_q[i] <= '0;
      end
    end
    if (st_q == SRdWait || st_q == SUpWait) c_q <= rd_q;
    if (div_done) rel_q <= div_rel;
    if (st_q == SSq) sq_q <= 48'(rel_q) * 48'(rel_q);
    if (st_q == SDecide) sum_q <= '0;
    else if (st_q == SAcc) sum_q <= sum_q + 50'(sq_q);
    else if (st_q == SCmp) sum_q <= '0;
    // blend in SUpMul, one product per cycle: (1-alpha)*c first, then alpha*s is added
    if (st_q == SUpMul) begin
      if (up_ph_q == 2'd0)
        tsum_q <= 52'(signed'({1'b0, OneQ16 - alpha})) * 52'(signed'(c_q)) + 52'sd32768;
      else
        tsum_q <= tsum_q + 52'(signed'({1'b0, alpha})) * 52'(signed'({sv, 16'h0000}));
    end
  end

endmodule
`default_nettype wire

>>> tb/online_leader_clustering_anomaly_tb.sv
`timescale 1ns / 1ps

module online_leader_clustering_anomaly_tb;
  import olca_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_anomaly;
    logic [15:0] anomaly_count;
    logic [4:0]  cluster_count;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] element_value_i = '0;
  logic        last_element_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        is_anomaly_o;
  logic [15:0] anomaly_count_o;
  logic [4:0]  cluster_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  online_leader_clustering_anomaly i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .element_value_i, .last_element_i,
    .out_valid_o, .out_ready_i, .status_o, .is_anomaly_o, .anomaly_count_o,
    .cluster_count_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the block's registers and state
  logic        mode_q = 1'b0;
  logic [15:0] limit_q = 16'd256;
  logic [16:0] alpha_q = 17'd32768;
  logic [15:0] train_len_q = 16'd1000;
  int          centroids[MaxClusters][Dims];
  int          vec_buf[Dims];
  int          elem_idx = 0;
  int          n_clusters = 0;
  bit          seeded = 0;
  int          trained = 0;
  int          anomalies = 0;

  verdict_t    verdict_q[$];
  int          errors = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          protos[4][Dims];

  function automatic longint unsigned rel_square(int c, int s);
    longint d;
    longint unsigned mag, den, rel;
    d = longint'(c) - longint'(s) * 65536;
    mag = (d < 0) ? -d : d;
    den = (c < 0) ? -longint'(c) : longint'(c);
    if (den == 0) rel = RelSat;
    else begin
      rel = (mag * 65536) / den;
      if (rel > RelSat) rel = RelSat;
    end
    return rel * rel;
  endfunction

  function automatic bit within_limit(int k);
    longint unsigned sum, lim;
    sum = 0;
    lim = longint'(limit_q) * 256;
    for (int j = 0; j < Dims; j++) sum += rel_square(centroids[k][j], vec_buf[j]);
    return sum < lim * lim;
  endfunction

  function automatic int smooth(int c, int s);
    longint a, t, q;
    a = (alpha_q > OneQ16) ? 65536 : longint'(alpha_q);
    t = (65536 - a) * longint'(c) + a * (longint'(s) * 65536) + 32768;
    if (t >= 0) q = t / 65536;
    else q = -((-t + 65535) / 65536);
    return int'(q);
  endfunction

  function automatic bit match_and_move();
    for (int k = 0; k < n_clusters && k < MaxClusters; k++) begin
      if (within_limit(k)) begin
        for (int j = 0; j < Dims; j++) centroids[k][j] = smooth(centroids[k][j], vec_buf[j]);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void store_vec(int k);
    for (int j = 0; j < Dims; j++) centroids[k][j] = vec_buf[j] * 65536;
  endfunction

  function automatic logic [1:0] train_state();
    if (trained < int'(train_len_q)) return StTraining;
    return StFinished;
  endfunction

  function automatic void bump_trained();
    if (trained < 65535) trained++;
  endfunction

  // advance the shadow state by one accepted item
  function automatic void cluster_element(logic signed [15:0] v, logic last);
    verdict_t r;
    if (elem_idx < Dims) begin
      vec_buf[elem_idx] = v;
      elem_idx++;
    end
    if (!last) return;
    for (int j = elem_idx; j < Dims; j++) vec_buf[j] = 0;
    elem_idx = 0;
    r.is_anomaly = 1'b0;
    if (mode_q) begin
      r.status = StDetect;
      if (!match_and_move()) begin
        r.is_anomaly = 1'b1;
        if (anomalies < 65535) anomalies++;
      end
    end else if (!seeded) begin
      store_vec(0);
      n_clusters = 1;
      seeded = 1;
      bump_trained();
      r.status = train_state();
    end else if (match_and_move()) begin
      bump_trained();
      r.status = train_state();
    end else begin
      r.is_anomaly = 1'b1;
      if (n_clusters >= MaxClusters) r.status = StFull;
      else begin
        store_vec(n_clusters);
        n_clusters++;
        if (n_clusters >= MaxClusters) r.status = StFull;
        else begin
          bump_trained();
          r.status = train_state();
        end
      end
    end
    r.anomaly_count = anomalies[15:0];
    r.cluster_count = n_clusters[4:0];
    verdict_q.push_back(r);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    verdict_t e;
    if (out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (is_anomaly_o !== e.is_anomaly) begin
          $error("is_anomaly: expected %0d, got %0d", e.is_anomaly, is_anomaly_o);
          errors++;
        end
        if (anomaly_count_o !== e.anomaly_count) begin
          $error("anomaly_count: expected %0d, got %0d", e.anomaly_count, anomaly_count_o);
          errors++;
        end
        if (cluster_count_o !== e.cluster_count) begin
          $error("cluster_count: expected %0d, got %0d", e.cluster_count, cluster_count_o);
          errors++;
        end
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 6000;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_item(logic [15:0] v, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_value_i <= v;
    last_element_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cluster_element(v, last);
  endtask

  task automatic send_vector(int v[], int n);
    for (int i = 0; i < n; i++) send_item(v[i][15:0], i == n - 1);
  endtask

  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMode:   mode_q = val[0];
      RegLimit:  limit_q = val[15:0];
      RegSmooth: alpha_q = val[16:0];
      RegTrain:  train_len_q = val[15:0];
      default: ;
    endcase
  endtask

  // mostly noisy copies of a few prototypes, the rest random or odd length
  task automatic random_vector();
    int v[];
    int n, p;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : Dims;
    v = new[n];
    p = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) != 0 && i < Dims)
        v[i] = protos[p][i] + $signed($urandom_range(400)) - 200;
      else
        v[i] = $signed({16'd0, 16'($urandom)}) - 32768;
    end
    send_vector(v, n);
  endtask

  task automatic set_phase(int ph);
    case (ph % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 66; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 66; end
      default: begin in_idle_pct = 6; out_stall_pct = 6; end
    endcase
  endtask

  task automatic test_detect_without_clusters();
    write_reg(RegMode, 1);
    send_vector('{100, -100, 0, 5}, 4);
    send_vector('{32767}, 1);
    drain();
  endtask

  task automatic test_seed_and_extremes();
    write_reg(RegMode, 0);
    write_reg(RegLimit, 65535);
    write_reg(RegSmooth, 131071);
    write_reg(RegTrain, 1);
    send_vector('{32767, -32768, 1, -1}, 4);
    send_vector('{32767, -32768, 2, -2}, 4);
    send_vector('{-32768, 32767, 0, 0}, 4);
    send_vector('{7}, 1);
    send_vector('{30000, -30000, 5, -5, 123, -456}, 6);
    drain();
  endtask

  task automatic test_random_training();
    write_reg(RegLimit, 256);
    write_reg(RegSmooth, 32768);
    write_reg(RegTrain, 65535);
    for (int ph = 0; ph < 4; ph++) begin
      set_phase(ph);
      for (int i = 0; i < 16; i++) random_vector();
      drain();
      write_reg(RegLimit, (ph == 1) ? 16'd40 : 16'($urandom_range(64, 2000)));
      write_reg(RegSmooth, (ph == 2) ? 17'd0 : 17'($urandom_range(65536)));
    end
    set_phase(0);
  endtask

  task automatic test_fill_table();
    write_reg(RegLimit, 0);
    write_reg(RegSmooth, 65536);
    while (n_clusters < MaxClusters) random_vector();
    for (int i = 0; i < 3; i++) random_vector();
    drain();
  endtask

  task automatic test_random_detection();
    write_reg(RegMode, 1);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegLimit, (ph == 0) ? 16'd65535 : 16'($urandom_range(65535) >> $urandom_range(10)));
      write_reg(RegSmooth, (ph == 3) ? 17'd65536 : 17'($urandom_range(131071)));
      write_reg(RegTrain, $urandom_range(1, 65535));
      set_phase(ph);
      if (ph == 5) hold_reqs++;
      for (int i = 0; i < 14; i++) random_vector();
      drain();
    end
  endtask

  initial begin
    for (int p = 0; p < 4; p++)
      for (int j = 0; j < Dims; j++) protos[p][j] = $urandom_range(1000, 30000) * (j % 2 ? -1 : 1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_detect_without_clusters();
    test_seed_and_extremes();
    test_random_training();
    test_fill_table();
    test_random_detection();
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
